// ===== src/pif_pkg.sv =====
// Shared types, character codes and helpers of the integer formatter.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps

package pif_pkg;

  // conversion kinds as carried in the input tuser
  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_OCT  = 3'd2,
    OP_HEXL = 3'd3,
    OP_HEXU = 3'd4,
    OP_PTR  = 3'd5
  } pif_op_e;

  localparam int VAL_BITS = 64;

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;

  // section boundaries of the text, each the index one past its section
  localparam int BND_PAD   = 0;
  localparam int BND_SIGN  = 1;
  localparam int BND_PRE   = 2;
  localparam int BND_ZERO  = 3;
  localparam int BND_DIG   = 4;
  localparam int BND_END   = 5;
  localparam int BND_COUNT = 6;

  // fixed characters of one item, handed from front to back
  typedef struct packed {
    logic [7:0] sign_char;
    logic [7:0] pre0;
    logic [7:0] pre1;
    logic       upper;
  } pif_hdr_t;

  // codes 6 and 7 fall back to unsigned decimal
  function automatic pif_op_e norm_op(logic [2:0] raw);
    pif_op_e op;
    case (raw)
      OP_SDEC, OP_UDEC, OP_OCT, OP_HEXL, OP_HEXU, OP_PTR: op = pif_op_e'(raw);
      default: op = OP_UDEC;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0000, d};
    end else begin
      c = (upper ? CH_UA : CH_LA) + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== src/pif_fifo.sv =====
// Two-entry descriptor queue between the formatter front and back ends.
// Generic in width; no package dependency.
`timescale 1ns / 1ps

module pif_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ===== src/pif_front.sv =====
// Front end: accepts an item, forms sign and magnitude, extracts digits
// (shift-add-3 for decimal), counts them and builds the text layout.
// Depends on pif_pkg.
`timescale 1ns / 1ps

module pif_front #(
  parameter  int MAX_DIGITS = 22,
  parameter  int MAX_FIELD  = 63,
  localparam int LW         = $clog2(MAX_DIGITS + 68)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  input  logic [87:0]                           s_tdata_i,
  input  logic [2:0]                            s_tuser_i,
  output logic                                  push_o,
  input  logic                                  full_i,
  output logic [MAX_DIGITS-1:0][3:0]            dig_o,
  output logic [pif_pkg::BND_COUNT-1:0][LW-1:0] bnd_o,
  output pif_pkg::pif_hdr_t                     hdr_o
);

  localparam int DW   = 4 * MAX_DIGITS;
  localparam int CW   = $clog2(MAX_DIGITS);
  localparam int NDW  = $clog2(MAX_DIGITS + 1);
  localparam int CNTW = $clog2(pif_pkg::VAL_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SCAN,
    ST_CALC,
    ST_PUSH
  } state_e;

  state_e                state_q;
  logic [CNTW-1:0]       cnt_q;

  pif_pkg::pif_op_e      op_q;
  logic [63:0]           mag_q;
  logic                  mag_nz_q, lj_q, zpad_q, pg_q, has_sign_q, alt_q;
  logic [5:0]            fw_q, pr_q;
  logic [7:0]            sign_q, pre0_q, pre1_q;
  logic [MAX_DIGITS-1:0][3:0] dig_q;
  logic [NDW-1:0]        nd_q;
  logic [1:0]            np_q;
  logic [LW-1:0]         zeros_q;

  // accept-side decode
  logic                  accept;
  pif_pkg::pif_op_e      op_in;
  logic [63:0]           v_in, mag_in;
  logic                  neg_in;
  logic [DW+63:0]        ext_in;
  logic [MAX_DIGITS-1:0][3:0] oct_ld, hex_ld, bcd_adj;
  logic [DW-1:0]         bcd_flat;

  // layout calculation
  logic                  empty_txt;
  logic [NDW-1:0]        nd_eff;
  logic [LW-1:0]         nd_w, s_w, fw_w, pr_w, sub_w, prec_zeros, zp_zeros, zeros_c;
  logic [1:0]            np_c;
  logic [7:0]            pre0_c, pre1_c;
  logic [LW-1:0]         len_w, pad_w, end_w, total_w;
  logic [LW-1:0]         b_pad, b_sign, b_pre, b_zero, b_dig;
  logic [3:0]            scan_dig;

  assign accept     = s_tvalid_i && (state_q == ST_IDLE);
  assign s_tready_o = state_q == ST_IDLE;

  assign op_in  = pif_pkg::norm_op(s_tuser_i);
  assign v_in   = s_tdata_i[63:0];
  assign neg_in = (op_in == pif_pkg::OP_SDEC) && v_in[63];
  assign mag_in = neg_in ? (~v_in + 64'd1) : v_in;
  assign ext_in = {{DW{1'b0}}, mag_in};

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      oct_ld[i]  = {1'b0, ext_in[3*i +: 3]};
      hex_ld[i]  = ext_in[4*i +: 4];
      bcd_adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
  end

  assign bcd_flat = bcd_adj;
  assign scan_dig = dig_q[cnt_q[CW-1:0]];

  // prefix, zero count and digit count once the digits are known
  always_comb begin
    empty_txt = !mag_nz_q && pg_q && (pr_q == 6'd0);
    nd_eff    = empty_txt ? '0 : nd_q;
    nd_w      = LW'(nd_eff);
    s_w       = LW'(has_sign_q);
    fw_w      = LW'(fw_q);
    pr_w      = LW'(pr_q);
    prec_zeros = (pg_q && (pr_w > nd_w)) ? pr_w - nd_w : '0;
    np_c   = 2'd0;
    pre0_c = pif_pkg::CH_ZERO;
    pre1_c = pif_pkg::CH_LX;
    case (op_q)
      pif_pkg::OP_PTR: begin
        np_c = 2'd2;
      end
      pif_pkg::OP_HEXL: begin
        if (alt_q && mag_nz_q) np_c = 2'd2;
      end
      pif_pkg::OP_HEXU: begin
        pre1_c = pif_pkg::CH_UX;
        if (alt_q && mag_nz_q) np_c = 2'd2;
      end
      pif_pkg::OP_OCT: begin
        // a leading zero only where the digits do not already start with one
        if (alt_q && (prec_zeros == '0) && (mag_nz_q || (nd_eff == '0))) np_c = 2'd1;
      end
      default: begin
        np_c = 2'd0;
      end
    endcase
    sub_w    = s_w + LW'(np_c) + nd_w;
    zp_zeros = (fw_w > sub_w) ? fw_w - sub_w : '0;
    if (pg_q) begin
      zeros_c = prec_zeros;
    end else if (zpad_q && !lj_q) begin
      zeros_c = zp_zeros;
    end else begin
      zeros_c = '0;
    end
  end

  // section boundaries for the back end
  always_comb begin
    len_w   = s_w + LW'(np_q) + zeros_q + LW'(nd_q);
    pad_w   = (fw_w > len_w) ? fw_w - len_w : '0;
    b_pad   = lj_q ? '0 : pad_w;
    b_sign  = b_pad + s_w;
    b_pre   = b_sign + LW'(np_q);
    b_zero  = b_pre + zeros_q;
    b_dig   = b_zero + LW'(nd_q);
    end_w   = b_dig + (lj_q ? pad_w : '0);
    total_w = (end_w > LW'(MAX_FIELD)) ? LW'(MAX_FIELD) : end_w;
  end

  always_comb begin
    bnd_o                     = '0;
    bnd_o[pif_pkg::BND_PAD]   = b_pad;
    bnd_o[pif_pkg::BND_SIGN]  = b_sign;
    bnd_o[pif_pkg::BND_PRE]   = b_pre;
    bnd_o[pif_pkg::BND_ZERO]  = b_zero;
    bnd_o[pif_pkg::BND_DIG]   = b_dig;
    bnd_o[pif_pkg::BND_END]   = total_w;
  end

  assign dig_o           = dig_q;
  assign hdr_o.sign_char = sign_q;
  assign hdr_o.pre0      = pre0_q;
  assign hdr_o.pre1      = pre1_q;
  assign hdr_o.upper     = op_q == pif_pkg::OP_HEXU;
  assign push_o          = (state_q == ST_PUSH) && !full_i && (total_w != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            if ((op_in == pif_pkg::OP_SDEC) || (op_in == pif_pkg::OP_UDEC)) begin
              state_q <= ST_DABBLE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_DABBLE: begin
          if (cnt_q == CNTW'(pif_pkg::VAL_BITS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_SCAN: begin
          if (cnt_q == CNTW'(MAX_DIGITS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_CALC;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        ST_CALC: begin
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!full_i || (total_w == '0)) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_in;
      mag_q      <= mag_in;
      mag_nz_q   <= mag_in != 64'd0;
      lj_q       <= s_tdata_i[64];
      alt_q      <= s_tdata_i[67];
      zpad_q     <= s_tdata_i[68];
      fw_q       <= s_tdata_i[74:69];
      pg_q       <= s_tdata_i[75];
      pr_q       <= s_tdata_i[81:76];
      nd_q       <= NDW'(1);
      has_sign_q <= (op_in == pif_pkg::OP_SDEC) &&
                    (neg_in || s_tdata_i[65] || s_tdata_i[66]);
      if (neg_in) begin
        sign_q <= pif_pkg::CH_MINUS;
      end else if (s_tdata_i[65]) begin
        sign_q <= pif_pkg::CH_PLUS;
      end else begin
        sign_q <= pif_pkg::CH_SPACE;
      end
      case (op_in)
        pif_pkg::OP_OCT:                                     dig_q <= oct_ld;
        pif_pkg::OP_HEXL, pif_pkg::OP_HEXU, pif_pkg::OP_PTR: dig_q <= hex_ld;
        default:                                             dig_q <= '0;
      endcase
    end else if (state_q == ST_DABBLE) begin
      // shift-add-3: one magnitude bit enters the BCD digits per cycle
      dig_q <= {bcd_flat[DW-2:0], mag_q[63]};
      mag_q <= {mag_q[62:0], 1'b0};
    end else if (state_q == ST_SCAN) begin
      if (scan_dig != 4'd0) nd_q <= NDW'(cnt_q) + NDW'(1);
    end else if (state_q == ST_CALC) begin
      nd_q    <= nd_eff;
      np_q    <= np_c;
      pre0_q  <= pre0_c;
      pre1_q  <= pre1_c;
      zeros_q <= zeros_c;
    end
  end

endmodule

// ===== src/pif_back.sv =====
// Back end: takes one layout descriptor from the queue and emits its text
// one character per item through a registered output stage. Depends on pif_pkg.
`timescale 1ns / 1ps

module pif_back #(
  parameter  int MAX_DIGITS = 22,
  localparam int LW         = $clog2(MAX_DIGITS + 68)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  empty_i,
  output logic                                  pop_o,
  input  logic [MAX_DIGITS-1:0][3:0]            dig_i,
  input  logic [pif_pkg::BND_COUNT-1:0][LW-1:0] bnd_i,
  input  pif_pkg::pif_hdr_t                     hdr_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [7:0]                            m_tdata_o,
  output logic                                  m_tlast_o
);

  localparam int CW = $clog2(MAX_DIGITS);

  logic                                  busy_q;
  logic [LW-1:0]                         idx_q;
  logic [MAX_DIGITS-1:0][3:0]            dig_q;
  logic [pif_pkg::BND_COUNT-1:0][LW-1:0] bnd_q;
  pif_pkg::pif_hdr_t                     hdr_q;
  logic                                  m_valid_q, m_last_q;
  logic [7:0]                            m_char_q;

  logic                                  load, last;
  logic [LW-1:0]                         dpos;
  logic [7:0]                            char_c;

  assign pop_o = !busy_q && !empty_i;
  assign load  = busy_q && (!m_valid_q || m_tready_i);
  assign last  = idx_q == (bnd_q[pif_pkg::BND_END] - LW'(1));
  // digits go out most significant first
  assign dpos  = bnd_q[pif_pkg::BND_DIG] - LW'(1) - idx_q;

  always_comb begin
    if (idx_q < bnd_q[pif_pkg::BND_PAD]) begin
      char_c = pif_pkg::CH_SPACE;
    end else if (idx_q < bnd_q[pif_pkg::BND_SIGN]) begin
      char_c = hdr_q.sign_char;
    end else if (idx_q < bnd_q[pif_pkg::BND_PRE]) begin
      char_c = (idx_q == bnd_q[pif_pkg::BND_SIGN]) ? hdr_q.pre0 : hdr_q.pre1;
    end else if (idx_q < bnd_q[pif_pkg::BND_ZERO]) begin
      char_c = pif_pkg::CH_ZERO;
    end else if (idx_q < bnd_q[pif_pkg::BND_DIG]) begin
      char_c = pif_pkg::digit_char(dig_q[dpos[CW-1:0]], hdr_q.upper);
    end else begin
      char_c = pif_pkg::CH_SPACE;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_char_q;
  assign m_tlast_o  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        idx_q <= idx_q + LW'(1);
        if (last) busy_q <= 1'b0;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dig_q <= dig_i;
      bnd_q <= bnd_i;
      hdr_q <= hdr_i;
    end
    if (load) begin
      m_char_q <= char_c;
      m_last_q <= last;
    end
  end

endmodule

// ===== src/printf_integer_formatter_core.sv =====
// Top level of the printf-style integer formatter: front end, descriptor
// queue and back end. Depends on pif_pkg, pif_front, pif_fifo and pif_back.
//
// One input item (a 64-bit value with conversion kind, flags, width and
// precision) becomes its formatted ASCII text, one character per output item,
// tlast on the final one; text longer than MAX_FIELD is cut to its first
// MAX_FIELD characters and text of length zero produces nothing. The front
// end runs the shift-add-3 converter on decimal kinds (one magnitude bit per
// cycle), then the digit count (one digit per cycle), a layout step and a
// push that waits while the queue is full; octal, hex and pointer skip it.
// The back end sends one character per cycle unless the output stalls and
// takes the next descriptor once the last character of the current one is
// loaded. A two-deep descriptor queue lets the front end work on the next
// item while the back end sends text, so the slower end sets the rate.
`timescale 1ns / 1ps

module printf_integer_formatter_core #(
  parameter int MAX_DIGITS = 22,
  parameter int MAX_FIELD  = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // value[63:0], left_align, plus_flag, space_flag, alternate_flag,
  // zero_pad_flag, field_width[5:0], precision_given, digit_precision[5:0]
  input  logic [87:0] s_axis_tdata_i,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_char[7:0]
  output logic [7:0]  m_axis_tdata_o,
  // last_char
  output logic        m_axis_tlast_o
);

  localparam int LW = $clog2(MAX_DIGITS + 68);
  localparam int QW = 4 * MAX_DIGITS + pif_pkg::BND_COUNT * LW + $bits(pif_pkg::pif_hdr_t);

  logic                                  push, full, pop, empty;
  logic [MAX_DIGITS-1:0][3:0]            dig_f, dig_b;
  logic [pif_pkg::BND_COUNT-1:0][LW-1:0] bnd_f, bnd_b;
  pif_pkg::pif_hdr_t                     hdr_f, hdr_b;
  logic [QW-1:0]                         q_din, q_dout;

  pif_front #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_o(s_axis_tready_o),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .push_o    (push),
    .full_i    (full),
    .dig_o     (dig_f),
    .bnd_o     (bnd_f),
    .hdr_o     (hdr_f)
  );

  assign q_din = {dig_f, bnd_f, hdr_f};

  pif_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (q_din),
    .full_o (full),
    .pop_i  (pop),
    .dout_o (q_dout),
    .empty_o(empty)
  );

  assign {dig_b, bnd_b, hdr_b} = q_dout;

  pif_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .pop_o     (pop),
    .dig_i     (dig_b),
    .bnd_i     (bnd_b),
    .hdr_i     (hdr_b),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o),
    .m_tlast_o (m_axis_tlast_o)
  );

endmodule

// ===== src/pif_checker.sv =====
// Port-level checks of the integer formatter, bound to its top level.
// Depends on pif_pkg and printf_integer_formatter_core.
`timescale 1ns / 1ps

module pif_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic [7:0] c;
  assign c = m_axis_tdata_o;

  // every clock edge with reset asserted leaves no character offered
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // the front end is busy after taking an item
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again straight after an item");

  // only characters of the formatted alphabet ever leave
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (c == pif_pkg::CH_SPACE) || (c == pif_pkg::CH_PLUS) || (c == pif_pkg::CH_MINUS) ||
      ((c >= pif_pkg::CH_ZERO) && (c <= pif_pkg::CH_ZERO + 8'd9)) ||
      ((c >= pif_pkg::CH_UA) && (c <= pif_pkg::CH_UA + 8'd5)) || (c == pif_pkg::CH_UX) ||
      ((c >= pif_pkg::CH_LA) && (c <= pif_pkg::CH_LA + 8'd5)) || (c == pif_pkg::CH_LX))
    else $error("character outside the formatted alphabet");

endmodule

bind printf_integer_formatter_core pif_checker u_pif_checker (.*);
